[sv/led_command_byte_parser_macros.svh]
// ----------------------------------------------------------------------------
// LED command byte parser assertion macros
// Shared concurrent assertion shorthands, sampled on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef LED_COMMAND_BYTE_PARSER_MACROS_SVH
`define LED_COMMAND_BYTE_PARSER_MACROS_SVH

// Same-cycle implication.
`define LCBP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lcbp assertion failed");

// Next-cycle implication.
`define LCBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lcbp assertion failed");

`endif

[sv/lcbp_pkg.sv]
// ----------------------------------------------------------------------------
// LED command byte parser package
// Command codes, parse phases, sizes and the result struct.
// ----------------------------------------------------------------------------
package lcbp_pkg;

  localparam int unsigned LedCount   = 32;
  localparam int unsigned MeterCount = 4;
  localparam int unsigned FrameBytes = (LedCount + 7) / 8;
  localparam int unsigned LedIdxW    = $clog2(LedCount);
  localparam int unsigned MeterIdxW  = (MeterCount > 1) ? $clog2(MeterCount) : 1;
  localparam int unsigned ByteIdxW   = (FrameBytes > 1) ? $clog2(FrameBytes) : 1;

  localparam logic [7:0] CmdSetLed = 8'h73;  // 's'
  localparam logic [7:0] CmdBuffer = 8'h62;  // 'b'
  localparam logic [7:0] CmdRandom = 8'h72;  // 'r'
  localparam logic [7:0] CmdMeter  = 8'h61;  // 'a'

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LED_NUM = 3'd2,
    PH_LED_VAL = 3'd3,
    PH_BUF     = 3'd4,
    PH_MET_NUM = 3'd5,
    PH_MET_VAL = 3'd6
  } lcbp_phase_e;

  typedef struct packed {
    logic [LedCount-1:0]              frame_bits;
    logic                             random_mode;
    logic [MeterCount-1:0][7:0]       meters;
    logic                             command_done;
  } lcbp_result_t;

endpackage

[sv/lcbp_in_stage.sv]
// ----------------------------------------------------------------------------
// LED command byte parser input stage
// Registers one received byte; refills in the cycle the held beat moves on.
// ----------------------------------------------------------------------------
module lcbp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);
  import lcbp_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       take;

  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (take) begin
      valid_d = 1'b1;
      byte_d  = rx_byte_i;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

[sv/lcbp_cmd_fsm.sv]
// ----------------------------------------------------------------------------
// LED command byte parser command state machine
// Parses one byte per step, updates frames, random flag and meters.
// ----------------------------------------------------------------------------
`include "led_command_byte_parser_macros.svh"

module lcbp_cmd_fsm (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  output lcbp_pkg::lcbp_result_t result_o
);
  import lcbp_pkg::*;

  lcbp_phase_e                phase_q, phase_d;
  logic [7:0]                 arg_q, arg_d;
  logic [LedCount-1:0]        front_q, front_d;
  logic [LedCount-1:0]        back_q, back_d;
  logic [LedCount-1:0]        back_fill;
  logic                       rand_q, rand_d;
  logic [MeterCount-1:0][7:0] meter_q, meter_d;
  logic                       done;

  always_comb begin
    phase_d   = phase_q;
    arg_d     = arg_q;
    front_d   = front_q;
    back_d    = back_q;
    rand_d    = rand_q;
    meter_d   = meter_q;
    done      = 1'b0;
    back_fill = back_q;
    back_fill[arg_q[ByteIdxW-1:0]*8 +: 8] = byte_i;
    if (step_i) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (byte_i == CmdSetLed) begin
            phase_d = PH_LED_NUM;
          end else if (byte_i == CmdBuffer) begin
            arg_d   = 8'd0;
            phase_d = PH_BUF;
          end else if (byte_i == CmdRandom) begin
            rand_d = 1'b1;
          end else if (byte_i == CmdMeter) begin
            arg_d   = 8'd0;
            phase_d = PH_MET_NUM;
          end
        end
        PH_LED_NUM: begin
          arg_d   = byte_i;
          phase_d = PH_LED_VAL;
        end
        PH_LED_VAL: begin
          // out-of-range LED number completes without touching the frame
          if (arg_q < 8'(LedCount)) begin
            front_d[arg_q[LedIdxW-1:0]] = (byte_i != 8'd0);
          end
          rand_d  = 1'b0;
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
        PH_BUF: begin
          arg_d = arg_q + 8'd1;
          if (arg_d >= 8'(FrameBytes)) begin
            front_d = back_fill;
            back_d  = front_q;
            rand_d  = 1'b0;
            phase_d = PH_IDLE;
            done    = 1'b1;
          end else begin
            back_d = back_fill;
          end
        end
        PH_MET_NUM: begin
          arg_d   = (byte_i < 8'(MeterCount)) ? byte_i : 8'd0;
          phase_d = PH_MET_VAL;
        end
        PH_MET_VAL: begin
          meter_d[arg_q[MeterIdxW-1:0]] = byte_i;
          rand_d  = 1'b0;
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      arg_q   <= 8'd0;
      front_q <= '0;
      back_q  <= '0;
      rand_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      arg_q   <= arg_d;
      front_q <= front_d;
      back_q  <= back_d;
      rand_q  <= rand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    meter_q <= meter_d;
  end

  assign result_o.frame_bits   = front_d;
  assign result_o.random_mode  = rand_d;
  assign result_o.meters       = meter_d;
  assign result_o.command_done = done;

  `LCBP_ASSERT_NEXT(a_done_to_idle, step_i && done, phase_q == PH_IDLE)
  `LCBP_ASSERT_IMPL(a_done_clears_random, done, !rand_d)
  `LCBP_ASSERT_NEXT(a_random_cmd, step_i && phase_q == PH_IDLE && byte_i == CmdRandom, rand_q)
  `LCBP_ASSERT_NEXT(a_hold_when_idle, !step_i,
                    $stable(phase_q) && $stable(front_q) && $stable(back_q) && $stable(rand_q))

endmodule

[sv/lcbp_out_stage.sv]
// ----------------------------------------------------------------------------
// LED command byte parser result stage
// Holds one result beat until taken; reloads in the cycle it is taken.
// ----------------------------------------------------------------------------
module lcbp_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  lcbp_pkg::lcbp_result_t result_i,
  output logic                   can_load_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output lcbp_pkg::lcbp_result_t result_o
);
  import lcbp_pkg::*;

  logic         valid_q, valid_d;
  lcbp_result_t res_q, res_d;

  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = result_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

[sv/led_command_byte_parser.sv]
// ----------------------------------------------------------------------------
// LED command byte parser
// Serial command bytes in, LED frame, random flag and meter levels out.
// ----------------------------------------------------------------------------
// Every accepted byte gives exactly one result beat showing the state after
// that byte. A byte is held in the input register, is parsed in one pass,
// and lands in the result register; a new byte is taken every cycle while
// the result side keeps up. Commands: 's' n v sets LED n, 'b' plus four
// bytes loads the back frame and then swaps it in, 'r' selects random mode,
// 'a' m v sets meter m (index 4 or more means 0). Meter levels are undefined
// until first written.
module led_command_byte_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] frame_bits_o,
  output logic        random_mode_o,
  output logic [7:0]  meter_zero_o,
  output logic [7:0]  meter_one_o,
  output logic [7:0]  meter_two_o,
  output logic [7:0]  meter_three_o,
  output logic        command_done_o
);
  import lcbp_pkg::*;

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         can_load;
  logic         advance;
  lcbp_result_t step_res;
  lcbp_result_t out_res;

  assign advance = s1_valid && can_load;

  lcbp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte)
  );

  lcbp_cmd_fsm u_cmd_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (s1_byte),
    .result_o (step_res)
  );

  lcbp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .result_i    (step_res),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res)
  );

  assign frame_bits_o   = out_res.frame_bits;
  assign random_mode_o  = out_res.random_mode;
  assign meter_zero_o   = out_res.meters[0];
  assign meter_one_o    = out_res.meters[1];
  assign meter_two_o    = out_res.meters[2];
  assign meter_three_o  = out_res.meters[3];
  assign command_done_o = out_res.command_done;

endmodule
